// ----- rtl/pssd_pkg.sv -----
`default_nettype none
package pssd_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int SLOT_W = $clog2(WINDOW_MAX);
   localparam int WIN_W = $clog2(WINDOW_MAX + 1);

   localparam int SAMPLE_W = 10;
   localparam int SECTOR_W = 10;
   localparam int SUM_W = SAMPLE_W + SLOT_W;

   localparam int DIV_N = (SUM_W > 11) ? SUM_W : 11;
   localparam int DIV_D = 11;
   localparam int DIV_CNT_W = $clog2(DIV_N + 1);

   localparam int WINDOW_CFG_W = 5;
   localparam int SECTOR_CFG_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_COUNT = 1'b1;

   localparam logic [WINDOW_CFG_W-1:0] WINDOW_RESET = 5'd8;
   localparam logic [SECTOR_CFG_W-1:0] SECTOR_RESET = 10'd8;
   localparam logic [SECTOR_CFG_W-1:0] SECTOR_DEFAULT = 10'd1023;
   localparam logic [SAMPLE_W-1:0] VALUE_MAX = 10'd1023;
   localparam int FULL_SCALE = 1024;
   localparam logic [SAMPLE_W-1:0] CHANGE_LIMIT = 10'd2;

   typedef struct packed {
      logic             start;
      logic [DIV_N-1:0] dividend;
      logic [DIV_D-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_N-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/pssd_req_if.sv -----
`default_nettype none
interface pssd_req_if;
   logic                          valid;
   logic                          ready;
   logic [pssd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/pssd_rsp_if.sv -----
`default_nettype none
interface pssd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pssd_pkg::SAMPLE_W-1:0] smooth_value;
   logic [pssd_pkg::SECTOR_W-1:0] sector;
   logic                          changed;
   logic                          new_sector;

   modport source (output valid, output smooth_value, output sector, output changed,
                   output new_sector, input ready);
   modport sink (input valid, input smooth_value, input sector, input changed,
                 input new_sector, output ready);
endinterface
`default_nettype wire

// ----- rtl/pot_smoothing_sector_detector.sv -----
`default_nettype none
// Channel  Dir  Payload                                     Transfer
// req      in   sample                                      valid & ready
// rsp      out  smooth_value, sector, changed, new_sector   valid & ready
// csr      in   csr_index, csr_data                         csr_we
//
// One sample is handled at a time: after an input transfer the block sweeps the sample ring memory,
// one read a cycle, then makes three passes of the shared radix-2 divider before the next transfer.
// Synchronous reset clears the ring valid bits, the counters and the reported values.
// A result waiting in the output register does not stop the next sample from
// entering; only the final load waits for the output register to be free.
module pot_smoothing_sector_detector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   pssd_req_if.sink                                req,
   pssd_rsp_if.source                              rsp,
   input  wire logic                               csr_we,
   input  wire logic [pssd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pssd_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_WRITE     = 4'd1;
   localparam logic [3:0] S_READ      = 4'd2;
   localparam logic [3:0] S_SUMEND    = 4'd3;
   localparam logic [3:0] S_AVG_GO    = 4'd4;
   localparam logic [3:0] S_AVG_WAIT  = 4'd5;
   localparam logic [3:0] S_STEP_GO   = 4'd6;
   localparam logic [3:0] S_STEP_WAIT = 4'd7;
   localparam logic [3:0] S_SEC_GO    = 4'd8;
   localparam logic [3:0] S_SEC_WAIT  = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   logic [pssd_pkg::WINDOW_CFG_W-1:0] window_size_ff;
   logic [pssd_pkg::SECTOR_CFG_W-1:0] sector_count_ff;

   logic [3:0]                       state_ff, state_in;
   logic [pssd_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [pssd_pkg::SLOT_W-1:0]      fill_ff, fill_in;
   logic [pssd_pkg::SLOT_W-1:0]      cnt_ff, cnt_in;
   logic [pssd_pkg::WINDOW_MAX-1:0]  valid_ff, valid_in;
   logic                             rd_pend_ff;
   logic                             rd_ok_ff;
   logic [pssd_pkg::SAMPLE_W-1:0]    sample_ff, sample_in;
   logic [pssd_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [pssd_pkg::SAMPLE_W-1:0]    avg_ff, avg_in;
   logic [pssd_pkg::DIV_D-1:0]       step_ff, step_in;
   logic [pssd_pkg::SECTOR_W-1:0]    sec_ff, sec_in;
   logic [pssd_pkg::SAMPLE_W-1:0]    reported_ff, reported_in;
   logic [pssd_pkg::SECTOR_W-1:0]    prev_sec_ff, prev_sec_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pssd_pkg::SAMPLE_W-1:0]    out_value_ff, out_value_in;
   logic [pssd_pkg::SECTOR_W-1:0]    out_sector_ff, out_sector_in;
   logic                             out_changed_ff, out_changed_in;
   logic                             out_new_ff, out_new_in;

   logic [pssd_pkg::WIN_W-1:0]        win;
   logic [pssd_pkg::SLOT_W-1:0]       win_m1;
   logic [pssd_pkg::SECTOR_CFG_W-1:0] sectors;
   logic [pssd_pkg::SAMPLE_W-1:0]     diff;
   logic                              accept;
   logic                              load;
   logic                              ram_we;
   logic [pssd_pkg::SAMPLE_W-1:0]     ram_rdata;

   pssd_pkg::div_req_type div_req;
   pssd_pkg::div_rsp_type div_rsp;

   pssd_ram #(
      .WIDTH (pssd_pkg::SAMPLE_W),
      .DEPTH (pssd_pkg::WINDOW_MAX)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (sample_ff),
      .raddr (cnt_ff),
      .rdata (ram_rdata)
   );

   pssd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= pssd_pkg::WINDOW_RESET;
         sector_count_ff <= pssd_pkg::SECTOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pssd_pkg::CSR_WINDOW_SIZE: begin
               window_size_ff <= csr_data[pssd_pkg::WINDOW_CFG_W-1:0];
            end
            pssd_pkg::CSR_SECTOR_COUNT: begin
               sector_count_ff <= csr_data[pssd_pkg::SECTOR_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (window_size_ff == '0) begin
         win = pssd_pkg::WIN_W'(1);
      end else if (window_size_ff > pssd_pkg::WINDOW_MAX) begin
         win = pssd_pkg::WIN_W'(pssd_pkg::WINDOW_MAX);
      end else begin
         win = pssd_pkg::WIN_W'(window_size_ff);
      end
      win_m1 = pssd_pkg::SLOT_W'(win - pssd_pkg::WIN_W'(1));
      sectors = (sector_count_ff == '0) ? pssd_pkg::SECTOR_DEFAULT : sector_count_ff;
   end

   assign accept = (state_ff == S_IDLE) && req.valid;
   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
   assign ram_we = (state_ff == S_WRITE);
   assign diff = (avg_ff > reported_ff) ? (avg_ff - reported_ff) : (reported_ff - avg_ff);

   always_comb begin
      div_req.start = (state_ff == S_AVG_GO) || (state_ff == S_STEP_GO)
                      || (state_ff == S_SEC_GO);
      unique case (state_ff)
         S_STEP_GO: begin
            div_req.dividend = pssd_pkg::DIV_N'(pssd_pkg::FULL_SCALE);
            div_req.divisor = pssd_pkg::DIV_D'(sectors);
         end
         S_SEC_GO: begin
            div_req.dividend = pssd_pkg::DIV_N'(avg_ff);
            div_req.divisor = step_ff;
         end
         default: begin
            div_req.dividend = pssd_pkg::DIV_N'(sum_ff);
            div_req.divisor = pssd_pkg::DIV_D'(fill_ff) + pssd_pkg::DIV_D'(1);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      sample_in = sample_ff;
      sum_in = sum_ff;
      avg_in = avg_ff;
      step_in = step_ff;
      sec_in = sec_ff;
      reported_in = reported_ff;
      prev_sec_in = prev_sec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_value_in = out_value_ff;
      out_sector_in = out_sector_ff;
      out_changed_in = out_changed_ff;
      out_new_in = out_new_ff;

      if (rd_pend_ff && rd_ok_ff) begin
         sum_in = sum_ff + pssd_pkg::SUM_W'(ram_rdata);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req.sample;
               sum_in = '0;
               cnt_in = '0;
               slot_in = (pssd_pkg::WIN_W'(slot_ff) >= win) ? '0 : slot_ff;
               fill_in = (fill_ff > win_m1) ? win_m1 : fill_ff;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            valid_in[slot_ff] = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            if (cnt_ff == fill_ff) begin
               state_in = S_SUMEND;
            end else begin
               cnt_in = cnt_ff + pssd_pkg::SLOT_W'(1);
            end
         end
         S_SUMEND: begin
            state_in = S_AVG_GO;
         end
         S_AVG_GO: begin
            state_in = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in = (div_rsp.quotient > pssd_pkg::DIV_N'(pssd_pkg::VALUE_MAX))
                        ? pssd_pkg::VALUE_MAX
                        : div_rsp.quotient[pssd_pkg::SAMPLE_W-1:0];
               if (fill_ff < win_m1) begin
                  fill_in = fill_ff + pssd_pkg::SLOT_W'(1);
               end
               if ((pssd_pkg::WIN_W'(slot_ff) + pssd_pkg::WIN_W'(1)) >= win) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + pssd_pkg::SLOT_W'(1);
               end
               state_in = S_STEP_GO;
            end
         end
         S_STEP_GO: begin
            state_in = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (div_rsp.done) begin
               step_in = div_rsp.quotient[pssd_pkg::DIV_D-1:0];
               state_in = S_SEC_GO;
            end
         end
         S_SEC_GO: begin
            state_in = S_SEC_WAIT;
         end
         S_SEC_WAIT: begin
            if (div_rsp.done) begin
               sec_in = (div_rsp.quotient > pssd_pkg::DIV_N'(pssd_pkg::VALUE_MAX))
                        ? pssd_pkg::VALUE_MAX
                        : div_rsp.quotient[pssd_pkg::SECTOR_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               out_value_in = avg_ff;
               out_sector_in = sec_ff;
               out_changed_in = diff > pssd_pkg::CHANGE_LIMIT;
               out_new_in = sec_ff != prev_sec_ff;
               if (diff > pssd_pkg::CHANGE_LIMIT) begin
                  reported_in = avg_ff;
               end
               prev_sec_in = sec_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff <= '0;
         fill_ff <= '0;
         cnt_ff <= '0;
         valid_ff <= '0;
         rd_pend_ff <= 1'b0;
         reported_ff <= '0;
         prev_sec_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
         rd_pend_ff <= (state_ff == S_READ);
         reported_ff <= reported_in;
         prev_sec_ff <= prev_sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= valid_ff[cnt_ff];
      sample_ff <= sample_in;
      sum_ff <= sum_in;
      avg_ff <= avg_in;
      step_ff <= step_in;
      sec_ff <= sec_in;
      out_value_ff <= out_value_in;
      out_sector_ff <= out_sector_in;
      out_changed_ff <= out_changed_in;
      out_new_ff <= out_new_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.smooth_value = out_value_ff;
   assign rsp.sector = out_sector_ff;
   assign rsp.changed = out_changed_ff;
   assign rsp.new_sector = out_new_ff;

   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_DONE && state_ff != S_STEP_GO
       && state_ff != S_STEP_WAIT && state_ff != S_SEC_GO && state_ff != S_SEC_WAIT)
      |-> (fill_ff <= win_m1))
      else $error("fill count beyond the window during a sample");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> !$changed(out_value_ff) && rsp_valid_ff)
      else $error("waiting result overwritten before its transfer");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_AVG_WAIT || state_ff == S_STEP_WAIT
                        || state_ff == S_SEC_WAIT))
      else $error("divider finished outside a wait state");

   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_READ || state_ff == S_SUMEND))
      else $error("ring read data arrived outside the sweep");

endmodule
`default_nettype wire

// ----- rtl/pssd_ram.sv -----
`default_nettype none
module pssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/pssd_div.sv -----
`default_nettype none
module pssd_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pssd_pkg::div_req_type div_req,
   output pssd_pkg::div_rsp_type      div_rsp
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [pssd_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [pssd_pkg::DIV_D-1:0]     rem_ff;
   logic [pssd_pkg::DIV_N-1:0]     quo_ff;
   logic [pssd_pkg::DIV_D-1:0]     dvs_ff;

   logic [pssd_pkg::DIV_D:0] trial;
   logic [pssd_pkg::DIV_D:0] diff;
   logic                     ge;

   always_comb begin
      trial = {rem_ff, quo_ff[pssd_pkg::DIV_N-1]};
      ge = trial >= {1'b0, dvs_ff};
      diff = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= pssd_pkg::DIV_CNT_W'(pssd_pkg::DIV_N);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - pssd_pkg::DIV_CNT_W'(1);
            if (cnt_ff == pssd_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[pssd_pkg::DIV_D-1:0] : trial[pssd_pkg::DIV_D-1:0];
         quo_ff <= {quo_ff[pssd_pkg::DIV_N-2:0], ge};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ----- tb/pot_smoothing_sector_detector_tb.sv -----
`timescale 1ns / 1ps
module pot_smoothing_sector_detector_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_SAMPLES = 94;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [pssd_pkg::SAMPLE_W-1:0] smooth_value;
      logic [pssd_pkg::SECTOR_W-1:0] sector;
      logic                          changed;
      logic                          new_sector;
   } reading_type;

   class pot_tracker;
      bit [pssd_pkg::WINDOW_CFG_W-1:0] window_cfg = pssd_pkg::WINDOW_RESET;
      bit [pssd_pkg::SECTOR_CFG_W-1:0] sector_cfg = pssd_pkg::SECTOR_RESET;
      bit [pssd_pkg::SAMPLE_W-1:0]     ring [pssd_pkg::WINDOW_MAX];
      int unsigned                     slot;
      int unsigned                     fill;
      bit [pssd_pkg::SAMPLE_W-1:0]     reported;
      bit [pssd_pkg::SECTOR_W-1:0]     last_sector;
      reading_type                     pending [$];
      int unsigned                     errors;

      function void note_sample(bit [pssd_pkg::SAMPLE_W-1:0] s);
         int unsigned w, secs, total, avg, sec, diff, i;
         reading_type r;
         w = (window_cfg == 0) ? 1 : ((window_cfg > pssd_pkg::WINDOW_MAX)
                                      ? pssd_pkg::WINDOW_MAX : window_cfg);
         if (slot >= w) slot = 0;
         if (fill > w - 1) fill = w - 1;
         ring[slot] = s;
         total = 0;
         for (i = 0; i <= fill; i++) total += ring[i];
         avg = total / (fill + 1);
         if (avg > pssd_pkg::VALUE_MAX) avg = pssd_pkg::VALUE_MAX;
         if (fill < w - 1) fill++;
         slot++;
         if (slot >= w) slot = 0;
         secs = (sector_cfg == 0) ? pssd_pkg::SECTOR_DEFAULT : sector_cfg;
         sec = avg / (pssd_pkg::FULL_SCALE / secs);
         if (sec > pssd_pkg::VALUE_MAX) sec = pssd_pkg::VALUE_MAX;
         r.smooth_value = pssd_pkg::SAMPLE_W'(avg);
         r.sector = pssd_pkg::SECTOR_W'(sec);
         diff = (avg > reported) ? avg - reported : reported - avg;
         r.changed = (diff > pssd_pkg::CHANGE_LIMIT);
         if (r.changed) reported = pssd_pkg::SAMPLE_W'(avg);
         r.new_sector = (sec != last_sector);
         if (r.new_sector) last_sector = pssd_pkg::SECTOR_W'(sec);
         pending.push_back(r);
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (pending.size() == 0) begin
            $error("smooth_value expected none actual %0d", got.smooth_value);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.smooth_value !== want.smooth_value) begin
            $error("smooth_value expected %0d actual %0d", want.smooth_value, got.smooth_value);
            errors++;
         end
         if (got.sector !== want.sector) begin
            $error("sector expected %0d actual %0d", want.sector, got.sector);
            errors++;
         end
         if (got.changed !== want.changed) begin
            $error("changed expected %0d actual %0d", want.changed, got.changed);
            errors++;
         end
         if (got.new_sector !== want.new_sector) begin
            $error("new_sector expected %0d actual %0d", want.new_sector, got.new_sector);
            errors++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [pssd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pssd_pkg::CSR_DATA_W-1:0] csr_data;

   pssd_req_if req_if ();
   pssd_rsp_if rsp_if ();

   pot_tracker tracker;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         rsp_hold;
   int         cycle_count;

   pot_smoothing_sector_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pot_smoothing_sector_detector: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_reading('{smooth_value: rsp_if.smooth_value, sector: rsp_if.sector,
                                 changed: rsp_if.changed, new_sector: rsp_if.new_sector});
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_sample(input logic [pssd_pkg::SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_sample(s);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [pssd_pkg::CSR_DATA_W-1:0] window_data,
                              input logic [pssd_pkg::CSR_DATA_W-1:0] sector_data);
      drain();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= pssd_pkg::CSR_WINDOW_SIZE;
      csr_data <= window_data;
      @(posedge clock);
      csr_index <= pssd_pkg::CSR_SECTOR_COUNT;
      csr_data <= sector_data;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.window_cfg = window_data[pssd_pkg::WINDOW_CFG_W-1:0];
      tracker.sector_cfg = sector_data[pssd_pkg::SECTOR_CFG_W-1:0];
   endtask

   initial begin
      logic [pssd_pkg::SAMPLE_W-1:0]   at_reset [10];
      logic [pssd_pkg::SAMPLE_W-1:0]   single [4];
      logic [pssd_pkg::SAMPLE_W-1:0]   widest [3];
      logic [pssd_pkg::SAMPLE_W-1:0]   shrunk [3];
      logic [pssd_pkg::CSR_DATA_W-1:0] wdata, sdata;
      int                              p, style, level;

      at_reset = '{0, 1023, 1023, 1023, 0, 0, 1, 2, 1023, 512};
      single = '{1023, 1021, 1020, 0};
      widest = '{1023, 1023, 1};
      shrunk = '{300, 301, 302};
      tracker = new;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = pssd_pkg::CSR_WINDOW_SIZE;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      rsp_hold = 0;
      cycle_count = 0;
      send_idle_pct = 22;
      recv_idle_pct = 45;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (at_reset[i]) send_sample(at_reset[i]);
      reconfigure(10'd1, 10'd0);
      foreach (single[i]) send_sample(single[i]);
      reconfigure(10'd0, 10'd1023);
      send_sample(10'd5);
      send_sample(10'd700);
      reconfigure(10'd31, 10'd1);
      foreach (widest[i]) send_sample(widest[i]);
      reconfigure(10'd3, 10'd512);
      foreach (shrunk[i]) send_sample(shrunk[i]);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 4)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 45;
            end
            1: begin
               send_idle_pct = 45;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p)
            0: begin
               wdata = 10'd16;
               sdata = 10'd1023;
            end
            1: begin
               wdata = 10'd1;
               sdata = 10'd1;
            end
            2: begin
               wdata = 10'd0;
               sdata = 10'd0;
            end
            3: begin
               wdata = 10'h3FF;
               sdata = 10'd2;
            end
            default: begin
               wdata = pssd_pkg::CSR_DATA_W'($urandom_range(0, 1023));
               sdata = pssd_pkg::CSR_DATA_W'($urandom_range(0, 1023));
            end
         endcase
         reconfigure(wdata, sdata);
         if (p == 1) rsp_hold = 600;
         style = $urandom_range(0, 5);
         level = $urandom_range(0, 1023);
         repeat (PHASE_SAMPLES) begin
            case (style)
               0: level = $urandom_range(0, 1023);
               1: level = $urandom_range(0, 1) ? 1023 - $urandom_range(0, 3) : $urandom_range(0, 3);
               default: begin
                  if (style == 2 && $urandom_range(0, 19) == 0) level = $urandom_range(0, 1023);
                  else level = level + int'($urandom_range(0, 8)) - 4;
               end
            endcase
            if (level < 0) level = 0;
            if (level > 1023) level = 1023;
            send_sample(pssd_pkg::SAMPLE_W'(level));
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("pot_smoothing_sector_detector: match");
      end else begin
         $display("pot_smoothing_sector_detector: mismatch");
      end
      $finish;
   end
endmodule
